### src/prfl_pkg.sv
package prfl_pkg;

  localparam int unsigned PAGE_IN_W = 16;
  localparam int unsigned AGE_W     = 16;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned FIDX_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 4;

  localparam logic [AGE_W-1:0] AGE_MAX   = '1;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'd1;

  localparam logic [CFG_DAT_W-1:0] FRAMES_IN_USE_RST = 4'd8;

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_SCAN,
    ST_COMMIT
  } step_e;

  typedef enum logic [1:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_MORE,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic  acc;
    logic  rd;
    logic  ev;
    logic  commit;
    cond_e cond;
    step_e jmp_t;
    step_e jmp_f;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic more;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic              is_fault;
    logic [FIDX_W-1:0] frame_index;
    logic [CNT_W-1:0]  fault_total;
  } result_t;

  function automatic ctrl_t ucode(step_e step);
    ctrl_t w;
    w = '{acc: 1'b0, rd: 1'b0, ev: 1'b0, commit: 1'b0,
          cond: C_ALWAYS, jmp_t: ST_WAIT, jmp_f: ST_WAIT};
    unique case (step)
      ST_WAIT: begin
        w.acc   = 1'b1;
        w.cond  = C_IN_VALID;
        w.jmp_t = ST_SCAN;
        w.jmp_f = ST_WAIT;
      end
      ST_SCAN: begin
        w.rd    = 1'b1;
        w.ev    = 1'b1;
        w.cond  = C_MORE;
        w.jmp_t = ST_SCAN;
        w.jmp_f = ST_COMMIT;
      end
      ST_COMMIT: begin
        w.commit = 1'b1;
        w.cond   = C_OUT_FREE;
        w.jmp_t  = ST_WAIT;
        w.jmp_f  = ST_COMMIT;
      end
      default: begin
        w.cond  = C_ALWAYS;
        w.jmp_t = ST_WAIT;
        w.jmp_f = ST_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

### src/prfl_if.sv
interface prfl_in_if;
  logic                            valid;
  logic                            ready;
  logic [prfl_pkg::PAGE_IN_W-1:0]  page_number;
  logic                            start_new;

  modport source (output valid, output page_number, output start_new, input ready);
  modport sink   (input valid, input page_number, input start_new, output ready);
endinterface

interface prfl_out_if;
  logic                         valid;
  logic                         ready;
  logic                         is_fault;
  logic [prfl_pkg::FIDX_W-1:0]  frame_index;
  logic [prfl_pkg::CNT_W-1:0]   fault_total;

  modport source (output valid, output is_fault, output frame_index, output fault_total,
                  input ready);
  modport sink   (input valid, input is_fault, input frame_index, input fault_total,
                  output ready);
endinterface

### src/prfl_mem.sv
module prfl_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/prfl_seq.sv
module prfl_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prfl_pkg::stat_t   stat_i,
  output prfl_pkg::ctrl_t   ctrl_o,
  output prfl_pkg::step_e   step_o
);

  prfl_pkg::step_e step_q, step_d;
  prfl_pkg::ctrl_t ctrl;
  logic            cond;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= prfl_pkg::ST_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    ctrl = prfl_pkg::ucode(step_q);
    unique case (ctrl.cond)
      prfl_pkg::C_ALWAYS:   cond = 1'b1;
      prfl_pkg::C_IN_VALID: cond = stat_i.in_valid;
      prfl_pkg::C_MORE:     cond = stat_i.more;
      prfl_pkg::C_OUT_FREE: cond = stat_i.out_free;
      default:              cond = 1'b1;
    endcase
    step_d = cond ? ctrl.jmp_t : ctrl.jmp_f;
  end

  assign ctrl_o = ctrl;
  assign step_o = step_q;

endmodule

### src/prfl_dp.sv
module prfl_dp #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  prfl_pkg::ctrl_t                       ctrl_i,
  input  logic                                  in_fire_i,
  input  logic [prfl_pkg::PAGE_IN_W-1:0]        page_i,
  input  logic                                  start_i,
  input  logic                                  cmt_fire_i,
  input  logic [$clog2(FRAMES+1)-1:0]           n_i,
  input  logic                                  lru_i,
  output logic                                  more_o,
  output prfl_pkg::result_t                     result_o
);

  localparam int unsigned PW = (PAGE_BITS < prfl_pkg::PAGE_IN_W) ? PAGE_BITS
                                                                 : prfl_pkg::PAGE_IN_W;
  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);
  localparam int unsigned AW = prfl_pkg::AGE_W;
  localparam int unsigned EW = PW + AW;

  logic [PW-1:0]             page_q;
  logic [CW-1:0]             ptr_q;
  logic [IW-1:0]             rptr_q;
  logic                      hit_q, emp_q;
  logic [IW-1:0]             hit_idx_q, emp_idx_q, best_idx_q;
  logic [AW-1:0]             best_q;
  logic [FRAMES-1:0]         valid_q;
  logic [prfl_pkg::CNT_W-1:0] fault_q, fault_nx;

  logic          rd_fire, we, ev_valid;
  logic [IW-1:0] raddr, waddr, slot;
  logic [EW-1:0] rdata, wdata;
  logic [PW-1:0] rd_page;
  logic [AW-1:0] rd_age;

  assign more_o   = ptr_q < n_i;
  assign rd_fire  = ctrl_i.acc ? in_fire_i : (ctrl_i.rd & more_o);
  assign raddr    = ctrl_i.acc ? '0 : ptr_q[IW-1:0];
  assign rd_page  = rdata[EW-1:AW];
  assign rd_age   = rdata[AW-1:0];
  assign ev_valid = valid_q[rptr_q];
  assign slot     = hit_q ? hit_idx_q : (emp_q ? emp_idx_q : best_idx_q);

  always_comb begin
    we    = 1'b0;
    waddr = rptr_q;
    wdata = {rd_page, rd_age + AW'(1)};
    if (cmt_fire_i) begin
      we    = ~hit_q | lru_i;
      waddr = slot;
      wdata = {page_q, AW'(1)};
    end else if (ctrl_i.ev) begin
      we = ev_valid & (rd_age != prfl_pkg::AGE_MAX);
    end
  end

  always_comb begin
    if (hit_q || fault_q == prfl_pkg::COUNT_MAX) begin
      fault_nx = fault_q;
    end else begin
      fault_nx = fault_q + prfl_pkg::CNT_W'(1);
    end
  end

  assign result_o.is_fault    = ~hit_q;
  assign result_o.frame_index = prfl_pkg::FIDX_W'(slot);
  assign result_o.fault_total = fault_nx;

  prfl_mem #(
    .DEPTH (FRAMES),
    .AW    (IW),
    .DW    (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (rd_fire),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      rptr_q  <= '0;
      hit_q   <= 1'b0;
      emp_q   <= 1'b0;
      valid_q <= '0;
      fault_q <= '0;
    end else begin
      if (in_fire_i) begin
        ptr_q  <= CW'(1);
        rptr_q <= '0;
        hit_q  <= 1'b0;
        emp_q  <= 1'b0;
        if (start_i) begin
          valid_q <= '0;
          fault_q <= '0;
        end
      end else if (ctrl_i.ev) begin
        if (rd_fire) begin
          ptr_q  <= ptr_q + CW'(1);
          rptr_q <= ptr_q[IW-1:0];
        end
        if (ev_valid && rd_page == page_q && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!ev_valid && !emp_q) begin
          emp_q <= 1'b1;
        end
      end else if (cmt_fire_i) begin
        valid_q[slot] <= 1'b1;
        fault_q       <= fault_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      page_q <= page_i[PW-1:0];
    end else if (ctrl_i.ev) begin
      if (ev_valid && rd_page == page_q && !hit_q) begin
        hit_idx_q <= rptr_q;
      end
      if (!ev_valid && !emp_q) begin
        emp_idx_q <= rptr_q;
      end
      if (rptr_q == '0 || rd_age > best_q) begin
        best_q     <= rd_age;
        best_idx_q <= rptr_q;
      end
    end
  end

endmodule

### src/page_replacement_fifo_lru.sv
// Channel   | Dir | Handshake      | Beat payload
// page_i    | in  | valid / ready  | page_number[15:0], start_new
// result_o  | out | valid / ready  | is_fault, frame_index[2:0], fault_total[15:0]
// cfg       | in  | cfg_we_i       | cfg_idx_i[0], cfg_data_i[3:0]
//
// A reference takes an accept step, a scan of every active frame through the single
// read port of the frame store, and a commit step. Reset clears the valid bits and
// the fault count at once; there is no clearing pass. A stalled result_o holds only
// the commit step; the next beat is taken while an earlier result still waits.
module page_replacement_fifo_lru #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [prfl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [prfl_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  prfl_in_if.sink                            page_i,
  prfl_out_if.source                         result_o
);

  localparam int unsigned CW = $clog2(FRAMES + 1);

  logic                                policy_q;
  logic [prfl_pkg::CFG_DAT_W-1:0]      fiu_q;
  logic [CW-1:0]                       n_act;
  prfl_pkg::ctrl_t                     ctrl;
  prfl_pkg::stat_t                     stat;
  prfl_pkg::step_e                     step;
  prfl_pkg::result_t                   res, result_q;
  logic                                out_valid_q;
  logic                                in_fire, cmt_fire, more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b0;
      fiu_q    <= prfl_pkg::FRAMES_IN_USE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        prfl_pkg::REG_POLICY_MODE:   policy_q <= cfg_data_i[0];
        prfl_pkg::REG_FRAMES_IN_USE: fiu_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fiu_q == '0) begin
      n_act = CW'(1);
    end else if (32'(fiu_q) > FRAMES) begin
      n_act = CW'(FRAMES);
    end else begin
      n_act = CW'(fiu_q);
    end
  end

  assign page_i.ready  = ctrl.acc;
  assign in_fire       = page_i.valid & page_i.ready;
  assign stat.in_valid = page_i.valid;
  assign stat.more     = more;
  assign stat.out_free = ~out_valid_q | result_o.ready;
  assign cmt_fire      = ctrl.commit & stat.out_free;

  prfl_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .step_o (step)
  );

  prfl_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_fire_i  (in_fire),
    .page_i     (page_i.page_number),
    .start_i    (page_i.start_new),
    .cmt_fire_i (cmt_fire),
    .n_i        (n_act),
    .lru_i      (policy_q),
    .more_o     (more),
    .result_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmt_fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmt_fire) begin
      result_q <= res;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.is_fault    = result_q.is_fault;
  assign result_o.frame_index = result_q.frame_index;
  assign result_o.fault_total = result_q.fault_total;

`ifndef SYNTH
  a_accept_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> step == prfl_pkg::ST_SCAN)
    else $error("accepted beat did not start the frame scan");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step == prfl_pkg::ST_SCAN && !more) |=> step == prfl_pkg::ST_COMMIT)
    else $error("frame scan ran past the active frames");

  a_commit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmt_fire |=> (out_valid_q && step == prfl_pkg::ST_WAIT))
    else $error("commit did not load the result register");
`endif

endmodule
